// File: hdl/ssms_pkg.sv
// Package: sizes, widths and codes of the sorted sample merge store.
`timescale 1ns / 1ps
package ssms_pkg;
  localparam int STORE_DEPTH = 1024;
  localparam int BATCH_DEPTH = 256;
  localparam int STORE_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int STORE_CW = $clog2(STORE_DEPTH + 1);
  localparam int BATCH_AW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
  localparam int BATCH_CW = $clog2(BATCH_DEPTH + 1);
  localparam int ENTRY_W = 160;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_STORE_OV = 2'd1,
    ST_BATCH_OV = 2'd2,
    ST_UNSORTED = 2'd3
  } status_e;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;
endpackage

// File: hdl/sorted_sample_merge_store_unit.sv
// Top level: batch collection, two-bank merge sequencer and read port.
//
// channel  | direction | handshake       | payload
// command  | in        | start / busy    | command, sample_*, batch_end, read_index
// result   | out       | done_o strobe   | entry_count_o .. value_max_o
//
// Add without batch_end gives no result. Read: S_READ registers the entry and the result strobe.
// Batch end: each merged entry takes S_MRD (store RAM read latency) then S_MCMP
// (write), and a final S_MRD ends the merge; set by the single read port of each RAM.
// Reset empties store and batch by counts only; no clearing pass.
// For a read or a batch end, busy is high from acceptance to the result strobe; results are never held.
`timescale 1ns / 1ps
module sorted_sample_merge_store_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           command_i,
  input  logic signed [63:0]             sample_time_i,
  input  logic signed [63:0]             sample_value_i,
  input  logic [31:0]                    sample_weight_i,
  input  logic                           batch_end_i,
  input  logic [9:0]                     read_index_i,
  output logic                           done_o,
  output logic [10:0]                    entry_count_o,
  output logic [1:0]                     status_o,
  output logic signed [63:0]             entry_time_o,
  output logic signed [63:0]             entry_value_o,
  output logic [31:0]                    entry_weight_o,
  output logic                           range_valid_o,
  output logic signed [63:0]             time_min_o,
  output logic signed [63:0]             time_max_o,
  output logic signed [63:0]             value_min_o,
  output logic signed [63:0]             value_max_o
);
  import ssms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_MRD  = 4'b0100,
    S_MCMP = 4'b1000
  } state_e;

  state_e              state_q;
  logic                bank_q;
  logic [STORE_CW-1:0] scount_q;
  logic [BATCH_CW-1:0] bcount_q;
  logic [1:0]          flags_q;
  logic signed [63:0]  last_t_q;
  logic                hit_q;
  logic                done_q;
  status_e             status_q;
  logic [ENTRY_W-1:0]  entry_q;
  logic                seen_q, mseen_q;
  logic signed [63:0]  tmin_q, tmax_q, vmin_q, vmax_q;
  logic signed [63:0]  mtmin_q, mtmax_q, mvmin_q, mvmax_q;
  logic [BATCH_CW-1:0] i_q;
  logic [STORE_CW-1:0] j_q, n_q;

  logic                accept;
  logic                b_we, s_we;
  logic [BATCH_AW-1:0] b_raddr;
  logic [STORE_AW:0]   s_raddr, s_waddr;
  logic [ENTRY_W-1:0]  b_rdata, s_rdata, s_wdata, in_entry;
  logic signed [63:0]  bt, st, bv;
  logic                more, full, take_b, take_s;

  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);
  assign in_entry = {sample_time_i, sample_value_i, sample_weight_i};
  assign b_we     = accept && (command_i == CMD_ADD) && (32'(bcount_q) < BATCH_DEPTH);

  ssms_ram #(.WIDTH(ENTRY_W), .DEPTH(BATCH_DEPTH)) u_batch (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (bcount_q[BATCH_AW-1:0]),
    .wdata_i (in_entry),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  ssms_ram #(.WIDTH(ENTRY_W), .DEPTH(2 * STORE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign bt   = b_rdata[159:96];
  assign bv   = b_rdata[95:32];
  assign st   = s_rdata[159:96];
  assign more = (i_q < bcount_q) || (j_q < scount_q);
  assign full = (32'(n_q) >= STORE_DEPTH);

  assign b_raddr = i_q[BATCH_AW-1:0];
  assign s_raddr = (state_q == S_IDLE) ? {bank_q, STORE_AW'(read_index_i)}
                                       : {bank_q, j_q[STORE_AW-1:0]};
  assign s_waddr = {~bank_q, n_q[STORE_AW-1:0]};

  always_comb begin
    take_b = 1'b0;
    take_s = 1'b0;
    priority if (i_q >= bcount_q) begin
      take_s = 1'b1;
    end else if ((j_q >= scount_q) || (bt < st)) begin
      take_b = 1'b1;
    end else if (st < bt) begin
      take_s = 1'b1;
    end else begin
      take_b = 1'b1;
      take_s = 1'b1;
    end
  end

  assign s_we    = (state_q == S_MCMP);
  assign s_wdata = take_b ? b_rdata : s_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      bank_q   <= 1'b0;
      scount_q <= '0;
      bcount_q <= '0;
      flags_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      seen_q   <= 1'b0;
      tmin_q   <= '0;
      tmax_q   <= '0;
      vmin_q   <= '0;
      vmax_q   <= '0;
      i_q      <= '0;
      j_q      <= '0;
      n_q      <= '0;
      mseen_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (command_i == CMD_READ) begin
              state_q <= S_READ;
            end else begin
              if (b_we) begin
                bcount_q <= bcount_q + 1'b1;
                if ((bcount_q != '0) && (sample_time_i < last_t_q)) begin
                  flags_q[1] <= 1'b1;
                end
              end else begin
                flags_q[0] <= 1'b1;
              end
              if (batch_end_i) begin
                state_q <= S_MRD;
                i_q     <= '0;
                j_q     <= '0;
                n_q     <= '0;
                mseen_q <= seen_q;
              end
            end
          end
        end
        S_READ: begin
          done_q   <= 1'b1;
          status_q <= ST_OK;
          state_q  <= S_IDLE;
        end
        S_MRD: begin
          if (!more || full) begin
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
            bcount_q <= '0;
            flags_q  <= '0;
            if (more) begin
              status_q <= ST_STORE_OV;
            end else begin
              bank_q   <= ~bank_q;
              scount_q <= n_q;
              seen_q   <= mseen_q;
              tmin_q   <= mtmin_q;
              tmax_q   <= mtmax_q;
              vmin_q   <= mvmin_q;
              vmax_q   <= mvmax_q;
              status_q <= flags_q[0] ? ST_BATCH_OV : (flags_q[1] ? ST_UNSORTED : ST_OK);
            end
          end else begin
            state_q <= S_MCMP;
          end
        end
        S_MCMP: begin
          n_q     <= n_q + 1'b1;
          state_q <= S_MRD;
          if (take_s) begin
            j_q <= j_q + 1'b1;
          end
          if (take_b) begin
            i_q     <= i_q + 1'b1;
            mseen_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      last_t_q <= sample_time_i;
    end
    if (accept) begin
      hit_q <= (32'(read_index_i) < 32'(scount_q));
    end
    if (state_q == S_IDLE && accept && batch_end_i) begin
      mtmin_q <= tmin_q;
      mtmax_q <= tmax_q;
      mvmin_q <= vmin_q;
      mvmax_q <= vmax_q;
    end
    if (state_q == S_MCMP && take_b) begin
      if (!mseen_q || bt < mtmin_q) mtmin_q <= bt;
      if (!mseen_q || mtmax_q < bt) mtmax_q <= bt;
      if (!mseen_q || bv < mvmin_q) mvmin_q <= bv;
      if (!mseen_q || mvmax_q < bv) mvmax_q <= bv;
    end
    if (state_q == S_READ) begin
      entry_q <= hit_q ? s_rdata : '0;
    end else if (state_q == S_MRD) begin
      entry_q <= '0;
    end
  end

  assign done_o         = done_q;
  assign entry_count_o  = 11'(scount_q);
  assign status_o       = status_q;
  assign entry_time_o   = entry_q[159:96];
  assign entry_value_o  = entry_q[95:32];
  assign entry_weight_o = entry_q[31:0];
  assign range_valid_o  = seen_q;
  assign time_min_o     = tmin_q;
  assign time_max_o     = tmax_q;
  assign value_min_o    = vmin_q;
  assign value_max_o    = vmax_q;
endmodule

// File: hdl/ssms_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module ssms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: hdl/ssms_chk.sv
// Port-level checker for the sorted sample merge store, bound to the top level.
`timescale 1ns / 1ps
module ssms_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        command_i,
  input logic        done_o,
  input logic [10:0] entry_count_o,
  input logic        range_valid_o
);
  import ssms_pkg::*;

  a_no_double_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe on two cycles in a row");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CMD_READ) |=> busy)
    else $error("read transaction did not raise busy");

  a_busy_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("busy fell without a result");

  a_range_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(range_valid_o)) else $error("range_valid dropped");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(entry_count_o) <= STORE_DEPTH)) else $error("entry count too large");
endmodule

bind sorted_sample_merge_store_unit ssms_chk u_ssms_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .command_i     (command_i),
  .done_o        (done_o),
  .entry_count_o (entry_count_o),
  .range_valid_o (range_valid_o)
);
